@@ hdl/hav_pkg.sv @@
// ----------------------------------------------------------------------------
// hav_pkg
// Shared constants, types and the CORDIC arctangent table for the
// haversine distance pipeline.
// ----------------------------------------------------------------------------
package hav_pkg;
	localparam int CORDIC_STEPS    = 24;
	localparam int ANGLE_FRAC_BITS = 23;

	localparam int LAT_W    = 31;
	localparam int LON_W    = 32;
	localparam int DIST_W   = 33;
	localparam int DEG_W    = 34;
	localparam int MAG_W    = 33;
	localparam int PROD_W   = 64;
	localparam int NQ_W     = 38;
	localparam int RCP_W    = 39;
	localparam int RCP_LO   = 20;
	localparam int RCP_SH   = 44;
	localparam int PLO_W    = NQ_W + RCP_LO;
	localparam int PHI_W    = NQ_W + RCP_W - RCP_LO;
	localparam int PP_W     = NQ_W + RCP_W;
	localparam int RAD_STG  = 6;
	localparam int AW       = 34;
	localparam int FRAC     = 30;
	localparam int LANES    = 4;
	localparam int ROOTS    = 2;
	localparam int A_W      = 31;
	localparam int SQ_W     = 64;
	localparam int SQ_STEPS = 32;
	localparam int MUL_W    = 2 * AW;
	localparam int RAD_W    = 23;
	localparam int DP_W     = RAD_W + A_W;
	localparam int DSHIFT   = 21;

	localparam logic [30:0]           PI29     = 31'd1686629713;
	localparam logic signed [AW-1:0]  HALF_PI  = AW'(64'd1686629713);
	localparam logic signed [AW-1:0]  PI_Q     = AW'(64'd3373259426);
	localparam logic signed [AW-1:0]  ONE_Q    = AW'(64'd1073741824);
	localparam logic signed [AW-1:0]  KINV     = AW'(64'd652032874);
	localparam logic [A_W-1:0]        A_ONE    = A_W'(64'd1073741824);
	localparam logic [A_W-1:0]        A_HALFPI = A_W'(64'd1686629713);
	localparam logic [RAD_W-1:0]      RADIUS   = 23'd6371000;
	localparam logic [DP_W-1:0]       D_ROUND  = DP_W'(64'd1) << (DSHIFT - 1);

	// ceil(2^44 / 45), exact floor division for dividends below 2^38
	localparam logic [RCP_W-1:0]      RECIP45  = 39'd390937467654;

	localparam logic signed [DEG_W-1:0] LAT_LIM = DEG_W'(64'd90 << ANGLE_FRAC_BITS);
	localparam logic signed [DEG_W-1:0] LON_LIM = DEG_W'(64'd180 << ANGLE_FRAC_BITS);
	localparam logic [PROD_W-1:0] ROUND_FULL = PROD_W'(64'd45 << ANGLE_FRAC_BITS);
	localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(64'd90 << ANGLE_FRAC_BITS);

	// lanes 2 and 3 carry half-angles
	localparam logic [LANES-1:0] HALF_LANES = 4'b1100;

	typedef logic signed [AW-1:0]    ang_t;
	typedef logic signed [DEG_W-1:0] deg_t;
	typedef logic [A_W-1:0]          hterm_t;
	typedef logic signed [MUL_W-1:0] mul_t;

	function automatic ang_t atan_entry(input int i);
		ang_t r;
		r = '0;
		unique case (i)
			0: r = AW'(64'd843314856);
			1: r = AW'(64'd497837829);
			2: r = AW'(64'd263043836);
			3: r = AW'(64'd133525158);
			4: r = AW'(64'd67021686);
			5: r = AW'(64'd33543515);
			6: r = AW'(64'd16775850);
			7: r = AW'(64'd8388437);
			8: r = AW'(64'd4194282);
			9: r = AW'(64'd2097149);
			default: begin
				if (i <= 30)
					r = (AW'(1) << (30 - i)) - AW'(1);
			end
		endcase
		return r;
	endfunction
endpackage

@@ hdl/hav_rad.sv @@
// ----------------------------------------------------------------------------
// hav_rad
// Degrees to Q30 radians on four lanes: magnitude, multiply by pi,
// rounding shift, then division by 45 as a split reciprocal multiply.
// ----------------------------------------------------------------------------
module hav_rad import hav_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic vld_in,
	input  deg_t deg [LANES],
	output logic vld_out,
	output ang_t rad [LANES]
);
	logic [RAD_STG-1:0] v_s;
	logic              sgn_s1 [LANES];
	logic [MAG_W-1:0]  mag_s1 [LANES];
	logic              sgn_s2 [LANES];
	logic [PROD_W-1:0] prod_s2 [LANES];
	logic              sgn_s3 [LANES];
	logic [NQ_W-1:0]   n_s3 [LANES];
	logic              sgn_s4 [LANES];
	logic [PLO_W-1:0]  plo_s4 [LANES];
	logic [PHI_W-1:0]  phi_s4 [LANES];
	logic              sgn_s5 [LANES];
	logic [MAG_W-1:0]  q_s5 [LANES];
	logic [PP_W-1:0]   pp [LANES];
	ang_t              rad_q [LANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s <= '0;
		else if (en)
			v_s <= {v_s[RAD_STG-2:0], vld_in};
	end

	always_comb begin
		for (int l = 0; l < LANES; l++)
			pp[l] = (PP_W'(phi_s4[l]) << RCP_LO) + PP_W'(plo_s4[l]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < LANES; l++) begin
				sgn_s1[l]  <= deg[l][DEG_W-1];
				mag_s1[l]  <= deg[l][DEG_W-1] ? MAG_W'(-deg[l]) : MAG_W'(deg[l]);
				sgn_s2[l]  <= sgn_s1[l];
				prod_s2[l] <= PROD_W'(mag_s1[l]) * PROD_W'(PI29);
				sgn_s3[l]  <= sgn_s2[l];
				if (HALF_LANES[l])
					n_s3[l] <= NQ_W'((prod_s2[l] + ROUND_HALF) >> (ANGLE_FRAC_BITS + 2));
				else
					n_s3[l] <= NQ_W'((prod_s2[l] + ROUND_FULL) >> (ANGLE_FRAC_BITS + 1));
				sgn_s4[l]  <= sgn_s3[l];
				plo_s4[l]  <= PLO_W'(n_s3[l]) * PLO_W'(RECIP45[RCP_LO-1:0]);
				phi_s4[l]  <= PHI_W'(n_s3[l]) * PHI_W'(RECIP45[RCP_W-1:RCP_LO]);
				sgn_s5[l]  <= sgn_s4[l];
				q_s5[l]    <= MAG_W'(pp[l] >> RCP_SH);
				rad_q[l]   <= sgn_s5[l] ? -AW'(q_s5[l]) : AW'(q_s5[l]);
			end
		end
	end

	assign vld_out = v_s[RAD_STG-1];
	assign rad     = rad_q;
endmodule

@@ hdl/hav_sincos.sv @@
// ----------------------------------------------------------------------------
// hav_sincos
// Rotation-mode CORDIC on four lanes, one iteration per stage, with a
// quadrant fold in front and sign fix-up at the end.
// ----------------------------------------------------------------------------
module hav_sincos import hav_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic vld_in,
	input  ang_t th [LANES],
	output logic vld_out,
	output ang_t cosv [LANES],
	output ang_t sinv [LANES]
);
	logic [CORDIC_STEPS+1:0] v_s;
	ang_t cx_s [CORDIC_STEPS+1][LANES];
	ang_t cy_s [CORDIC_STEPS+1][LANES];
	ang_t cz_s [CORDIC_STEPS+1][LANES];
	logic neg_s [CORDIC_STEPS+1][LANES];
	ang_t cos_q [LANES];
	ang_t sin_q [LANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s <= '0;
		else if (en)
			v_s <= {v_s[CORDIC_STEPS:0], vld_in};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < LANES; l++) begin
				cx_s[0][l] <= KINV;
				cy_s[0][l] <= '0;
				priority if (th[l] > HALF_PI) begin
					cz_s[0][l]  <= th[l] - PI_Q;
					neg_s[0][l] <= 1'b1;
				end else if (th[l] < -HALF_PI) begin
					cz_s[0][l]  <= th[l] + PI_Q;
					neg_s[0][l] <= 1'b1;
				end else begin
					cz_s[0][l]  <= th[l];
					neg_s[0][l] <= 1'b0;
				end
				cos_q[l] <= neg_s[CORDIC_STEPS][l] ? -cx_s[CORDIC_STEPS][l]
				                                   : cx_s[CORDIC_STEPS][l];
				sin_q[l] <= neg_s[CORDIC_STEPS][l] ? -cy_s[CORDIC_STEPS][l]
				                                   : cy_s[CORDIC_STEPS][l];
			end
		end
	end

	for (genvar j = 1; j <= CORDIC_STEPS; j++) begin : g_rot
		localparam ang_t ATAN = atan_entry(j - 1);

		always_ff @(posedge clk) begin
			if (en) begin
				for (int l = 0; l < LANES; l++) begin
					neg_s[j][l] <= neg_s[j-1][l];
					if (!cz_s[j-1][l][AW-1]) begin
						cx_s[j][l] <= cx_s[j-1][l] - (cy_s[j-1][l] >>> (j - 1));
						cy_s[j][l] <= cy_s[j-1][l] + (cx_s[j-1][l] >>> (j - 1));
						cz_s[j][l] <= cz_s[j-1][l] - ATAN;
					end else begin
						cx_s[j][l] <= cx_s[j-1][l] + (cy_s[j-1][l] >>> (j - 1));
						cy_s[j][l] <= cy_s[j-1][l] - (cx_s[j-1][l] >>> (j - 1));
						cz_s[j][l] <= cz_s[j-1][l] + ATAN;
					end
				end
			end
		end
	end

	assign vld_out = v_s[CORDIC_STEPS+1];
	assign cosv    = cos_q;
	assign sinv    = sin_q;
endmodule

@@ hdl/hav_sqrt.sv @@
// ----------------------------------------------------------------------------
// hav_sqrt
// Digit-by-digit square roots of a and 1 - a (both scaled by 2^30),
// one result bit per stage.
// ----------------------------------------------------------------------------
module hav_sqrt import hav_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   en,
	input  logic   vld_in,
	input  hterm_t a,
	output logic   vld_out,
	output ang_t   ra,
	output ang_t   rb
);
	logic [SQ_STEPS:0] v_s;
	logic [SQ_W-1:0] sv_s [SQ_STEPS+1][ROOTS];
	logic [SQ_W-1:0] sr_s [SQ_STEPS+1][ROOTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s <= '0;
		else if (en)
			v_s <= {v_s[SQ_STEPS-1:0], vld_in};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sv_s[0][0] <= SQ_W'(a) << FRAC;
			sv_s[0][1] <= SQ_W'(A_ONE - a) << FRAC;
			sr_s[0][0] <= '0;
			sr_s[0][1] <= '0;
		end
	end

	for (genvar j = 1; j <= SQ_STEPS; j++) begin : g_root
		localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 * j);
		logic [SQ_W-1:0] trial [ROOTS];

		always_comb begin
			for (int l = 0; l < ROOTS; l++)
				trial[l] = sr_s[j-1][l] + BIT;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int l = 0; l < ROOTS; l++) begin
					if (sv_s[j-1][l] >= trial[l]) begin
						sv_s[j][l] <= sv_s[j-1][l] - trial[l];
						sr_s[j][l] <= (sr_s[j-1][l] >> 1) + BIT;
					end else begin
						sv_s[j][l] <= sv_s[j-1][l];
						sr_s[j][l] <= sr_s[j-1][l] >> 1;
					end
				end
			end
		end
	end

	assign vld_out = v_s[SQ_STEPS];
	assign ra      = AW'(sr_s[SQ_STEPS][0]);
	assign rb      = AW'(sr_s[SQ_STEPS][1]);
endmodule

@@ hdl/hav_atan.sv @@
// ----------------------------------------------------------------------------
// hav_atan
// Vectoring-mode CORDIC atan2 of the two roots, clamp of the half
// central angle, and scaling by the sphere radius.
// ----------------------------------------------------------------------------
module hav_atan import hav_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              vld_in,
	input  ang_t              ry,
	input  ang_t              rx,
	output logic              vld_out,
	output logic [DIST_W-1:0] distance
);
	logic [CORDIC_STEPS+2:0] v_s;
	ang_t vx_s [CORDIC_STEPS+1];
	ang_t vy_s [CORDIC_STEPS+1];
	ang_t vz_s [CORDIC_STEPS+1];
	hterm_t zc_s1;
	logic [DP_W-1:0] dp_s2;
	logic [DIST_W-1:0] dist_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s <= '0;
		else if (en)
			v_s <= {v_s[CORDIC_STEPS+1:0], vld_in};
	end

	assign vx_s[0] = rx;
	assign vy_s[0] = ry;
	assign vz_s[0] = '0;

	for (genvar j = 1; j <= CORDIC_STEPS; j++) begin : g_vec
		localparam ang_t ATAN = atan_entry(j - 1);

		always_ff @(posedge clk) begin
			if (en) begin
				if (!vy_s[j-1][AW-1]) begin
					vx_s[j] <= vx_s[j-1] + (vy_s[j-1] >>> (j - 1));
					vy_s[j] <= vy_s[j-1] - (vx_s[j-1] >>> (j - 1));
					vz_s[j] <= vz_s[j-1] + ATAN;
				end else begin
					vx_s[j] <= vx_s[j-1] - (vy_s[j-1] >>> (j - 1));
					vy_s[j] <= vy_s[j-1] + (vx_s[j-1] >>> (j - 1));
					vz_s[j] <= vz_s[j-1] - ATAN;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			priority if (vz_s[CORDIC_STEPS][AW-1])
				zc_s1 <= '0;
			else if (vz_s[CORDIC_STEPS] > HALF_PI)
				zc_s1 <= A_HALFPI;
			else
				zc_s1 <= A_W'(vz_s[CORDIC_STEPS]);
			dp_s2  <= DP_W'(RADIUS) * DP_W'(zc_s1);
			dist_q <= DIST_W'((dp_s2 + D_ROUND) >> DSHIFT);
		end
	end

	assign vld_out  = v_s[CORDIC_STEPS+2];
	assign distance = dist_q;
endmodule

@@ hdl/haversine_distance.sv @@
// ----------------------------------------------------------------------------
// haversine_distance
// Great-circle distance between two points given in fixed-point degrees.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries one item: lat_a, lon_a, lat_b,
// lon_b in degrees with 23 fraction bits. Output channel (out_valid/
// out_ready) returns distance in 1/256 m on a 6371 km sphere.
// The pipeline has 97 register stages from an accepted item to its
// result: 1 clamp stage, 6 for degree-to-radian conversion (a
// reciprocal multiply for the divide by 45), 26 for the sine/cosine
// CORDIC, 4 for the haversine products, 33 for the two square roots and
// 27 for the atan2 CORDIC and radius scaling.
// Throughput is one item per cycle while the receiver does not stall;
// every stage is registered and the whole pipeline advances together.
// When the receiver stalls with a result held in the output register,
// every stage holds and in_ready drops; nothing is lost or repeated.
// Out-of-range coordinates are clamped to +-90 / +-180 degrees.
// Reset clears all valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
module haversine_distance import hav_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [LAT_W-1:0]  lat_a,
	input  logic signed [LON_W-1:0]  lon_a,
	input  logic signed [LAT_W-1:0]  lat_b,
	input  logic signed [LON_W-1:0]  lon_b,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [DIST_W-1:0]        distance
);
	logic en;
	deg_t la, oa, lb, ob;
	deg_t deg_s1 [LANES];
	logic vld_s1;
	logic rad_vld, sc_vld, sq_vld;
	ang_t rad [LANES];
	ang_t cosv [LANES];
	ang_t sinv [LANES];
	mul_t p1_s2, p2_s2, p3_s2;
	logic vld_s2, vld_s3, vld_s4, vld_s5;
	ang_t t1_s3, c12_s3, so2_s3, t1_s4;
	mul_t p4_s4;
	logic signed [AW:0] asum;
	hterm_t a_s5;
	ang_t ra, rb;

	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	always_comb begin
		la = DEG_W'(lat_a);
		oa = DEG_W'(lon_a);
		lb = DEG_W'(lat_b);
		ob = DEG_W'(lon_b);
		if (la > LAT_LIM)  la = LAT_LIM;
		if (la < -LAT_LIM) la = -LAT_LIM;
		if (lb > LAT_LIM)  lb = LAT_LIM;
		if (lb < -LAT_LIM) lb = -LAT_LIM;
		if (oa > LON_LIM)  oa = LON_LIM;
		if (oa < -LON_LIM) oa = -LON_LIM;
		if (ob > LON_LIM)  ob = LON_LIM;
		if (ob < -LON_LIM) ob = -LON_LIM;
		asum = (AW+1)'(t1_s4) + (AW+1)'(AW'(p4_s4 >>> FRAC));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= sc_vld;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			deg_s1[0] <= la;
			deg_s1[1] <= lb;
			deg_s1[2] <= lb - la;
			deg_s1[3] <= ob - oa;
			p1_s2  <= MUL_W'(sinv[2]) * MUL_W'(sinv[2]);
			p2_s2  <= MUL_W'(cosv[0]) * MUL_W'(cosv[1]);
			p3_s2  <= MUL_W'(sinv[3]) * MUL_W'(sinv[3]);
			t1_s3  <= AW'(p1_s2 >>> FRAC);
			c12_s3 <= AW'(p2_s2 >>> FRAC);
			so2_s3 <= AW'(p3_s2 >>> FRAC);
			t1_s4  <= t1_s3;
			p4_s4  <= MUL_W'(c12_s3) * MUL_W'(so2_s3);
			priority if (asum < 0)
				a_s5 <= '0;
			else if (asum > (AW+1)'(ONE_Q))
				a_s5 <= A_ONE;
			else
				a_s5 <= A_W'(asum);
		end
	end

	hav_rad u_rad (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_in  (vld_s1),
		.deg     (deg_s1),
		.vld_out (rad_vld),
		.rad     (rad)
	);

	hav_sincos u_sincos (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_in  (rad_vld),
		.th      (rad),
		.vld_out (sc_vld),
		.cosv    (cosv),
		.sinv    (sinv)
	);

	hav_sqrt u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_in  (vld_s5),
		.a       (a_s5),
		.vld_out (sq_vld),
		.ra      (ra),
		.rb      (rb)
	);

	hav_atan u_atan (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vld_in   (sq_vld),
		.ry       (ra),
		.rx       (rb),
		.vld_out  (out_valid),
		.distance (distance)
	);
endmodule
